// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define RRV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// checked on every edge, reset included
`define RRV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");

`endif

// ===== sv/rrv_pkg.sv =====
// ----------------------------------------------------------------------------
// rrv_pkg
// Shared types and constants of the rounded rectangle vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rrv_pkg;

  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned NumSteps   = 6;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;
  localparam logic [1:0] RegCount  = 2'd3;

  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
  localparam logic [30:0] OneQ30    = 31'h4000_0000;

  localparam logic [7:0]  SIN_DIV [5] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [31:0] SIN_RCP [5] = '{32'd39045157, 32'd59652323, 32'd102261126,
                                          32'd214748364, 32'd715827882};
  localparam logic [7:0]  COS_DIV [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] COS_RCP [6] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                          32'd143165576, 32'd357913941, 32'd2147483648};

  typedef struct packed {
    logic [1:0]  corner;
    logic [1:0]  idx2;
    logic [16:0] frac;
  } item_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] r;
    logic        rounded;
  } geom_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  corner;
    logic [1:0]  idx2;
    logic        swap;
  } meta_t;

endpackage

`default_nettype wire

// ===== sv/rrv_fifo.sv =====
// ----------------------------------------------------------------------------
// rrv_fifo
// Short register queue between index front end and trig back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rrv_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rrv_pkg::item_t push_data_i,
  input  wire logic           pop_i,
  output rrv_pkg::item_t      head_o,
  output logic                full_o,
  output logic                empty_o
);

  rrv_pkg::item_t mem_q [rrv_pkg::FifoDepth];
  logic [$clog2(rrv_pkg::FifoDepth)-1:0] wptr_q, rptr_q;
  logic [$clog2(rrv_pkg::FifoDepth):0]   count_q;

  assign full_o  = (count_q == ($clog2(rrv_pkg::FifoDepth)+1)'(rrv_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  `RRV_ASSERT(a_no_overflow, !(push_i && full_o && !pop_i))
  `RRV_ASSERT(a_no_underflow, !(pop_i && empty_o))

endmodule

`default_nettype wire

// ===== sv/rrv_front.sv =====
// ----------------------------------------------------------------------------
// rrv_front
// Splits the vertex index into corner and arc step, then the step into an
// angle fraction, with two pipelined restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rrv_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [9:0]     vertex_index_i,
  input  wire logic [8:0]     arc_len_i,
  input  wire logic [7:0]     arc_div_i,
  input  wire logic           full_i,
  output logic                push_o,
  output rrv_pkg::item_t      push_data_o
);

  logic en;

  logic [9:0] v1_q;
  logic [9:0] idx_q  [10];
  logic [7:0] rem1_q [10];
  logic [9:0] quo1_q [10];

  logic [17:0] v2_q;
  logic [7:0]  rem2_q [18];
  logic [16:0] quo2_q [18];
  logic [1:0]  cor_q  [18];
  logic [1:0]  ix_q   [18];
  logic        kb_q;

  assign en          = !(v2_q[17] && full_i);
  assign in_stall_o  = !en;
  assign push_o      = v2_q[17] && !full_i;
  assign push_data_o = '{corner: cor_q[17], idx2: ix_q[17], frac: quo2_q[17]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= '0;
      v2_q <= '0;
    end else if (en) begin
      v1_q <= {v1_q[8:0], in_valid_i};
      v2_q <= {v2_q[16:0], v1_q[9]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q[0]  <= vertex_index_i;
      rem1_q[0] <= '0;
      quo1_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < 10; j++) begin : g_div1
    logic [8:0] tmp;
    logic       ge;
    logic [8:0] nrem;
    logic [9:0] nquo;
    assign tmp  = {rem1_q[j], idx_q[j][9-j]};
    assign ge   = (tmp >= arc_len_i);
    assign nrem = ge ? (tmp - arc_len_i) : tmp;
    assign nquo = {quo1_q[j][8:0], ge};
    if (j < 9) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en) begin
          idx_q[j+1]  <= idx_q[j];
          rem1_q[j+1] <= nrem[7:0];
          quo1_q[j+1] <= nquo;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem2_q[0] <= {1'b0, nrem[7:1]};
          kb_q      <= nrem[0];
          quo2_q[0] <= '0;
          cor_q[0]  <= (nquo > 10'd3) ? 2'd3 : nquo[1:0];
          ix_q[0]   <= idx_q[j][1:0];
        end
      end
    end
  end

  for (genvar j = 0; j < 17; j++) begin : g_div2
    logic [8:0] tmp;
    logic       ge;
    logic [8:0] nrem;
    assign tmp  = {rem2_q[j], (j == 0) ? kb_q : 1'b0};
    assign ge   = (tmp >= {1'b0, arc_div_i});
    assign nrem = ge ? (tmp - {1'b0, arc_div_i}) : tmp;
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem2_q[j+1] <= nrem[7:0];
        quo2_q[j+1] <= {quo2_q[j][15:0], ge};
        cor_q[j+1]  <= cor_q[j];
        ix_q[j+1]   <= ix_q[j];
      end
    end
  end

  `RRV_ASSERT(a_stall_on_full, (v2_q[17] && full_i) |-> (in_stall_o && !push_o))

endmodule

`default_nettype wire

// ===== sv/rrv_back.sv =====
// ----------------------------------------------------------------------------
// rrv_back
// Angle to radians, Horner sine and cosine, radius scaling and corner
// placement, ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rrv_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rrv_pkg::geom_t geom_i,
  input  wire rrv_pkg::item_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [17:0]         vertex_x_o,
  output logic [17:0]         vertex_y_o
);

  logic en;
  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && !empty_i;

  // radians
  logic           v_rad_q;
  logic [29:0]    rad_q;
  rrv_pkg::meta_t m_rad_q;
  logic           swap;
  logic [15:0]    ang;
  logic [47:0]    rad_prod;

  assign swap     = (head_i.frac > 17'h08000);
  assign ang      = swap ? 16'(17'h10000 - head_i.frac) : head_i.frac[15:0];
  assign rad_prod = 48'(ang) * 48'(rrv_pkg::HalfPiQ30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q   <= rad_prod[45:16];
      m_rad_q <= '{x: '0, x2: '0, corner: head_i.corner, idx2: head_i.idx2,
                   swap: swap};
    end
  end

  // Horner chain
  logic           vC_q [7];
  rrv_pkg::meta_t mC_q [7];
  logic [30:0]    ct_q [7];
  logic [30:0]    st_q [7];
  logic [59:0]    sq_prod;

  assign sq_prod = 60'(rad_q) * 60'(rad_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mC_q[0] <= '{x: rad_q, x2: sq_prod[59:30], corner: m_rad_q.corner,
                   idx2: m_rad_q.idx2, swap: m_rad_q.swap};
      ct_q[0] <= rrv_pkg::OneQ30;
      st_q[0] <= rrv_pkg::OneQ30;
    end
  end

  for (genvar i = 0; i < rrv_pkg::NumSteps; i++) begin : g_step
    logic           vA_q, vB_q;
    rrv_pkg::meta_t mA_q, mB_q;
    logic [29:0]    cpA_q, cpB_q, cqB_q;
    logic [29:0]    spA_q, spB_q, sqB_q;
    logic [60:0]    c_mul, s_mul;
    logic [61:0]    c_rcp, s_rcp;
    logic [37:0]    c_rem, s_rem;
    logic [29:0]    c_q, s_q;

    assign c_mul = 61'(mC_q[i].x2) * 61'(ct_q[i]);
    assign c_rcp = 62'(cpA_q) * 62'(rrv_pkg::COS_RCP[i]);
    assign c_rem = 38'(cpB_q) - 38'(cqB_q) * 38'(rrv_pkg::COS_DIV[i]);
    assign c_q   = cqB_q + 30'(c_rem >= 38'(rrv_pkg::COS_DIV[i]));

    if (i < 5) begin : g_sin
      assign s_mul = 61'(mC_q[i].x2) * 61'(st_q[i]);
      assign s_rcp = 62'(spA_q) * 62'(rrv_pkg::SIN_RCP[i]);
      assign s_rem = 38'(spB_q) - 38'(sqB_q) * 38'(rrv_pkg::SIN_DIV[i]);
      assign s_q   = sqB_q + 30'(s_rem >= 38'(rrv_pkg::SIN_DIV[i]));
    end else begin : g_sfin
      assign s_mul = 61'(mC_q[i].x) * 61'(st_q[i]);
      assign s_rcp = {spA_q, 32'd0};
      assign s_rem = '0;
      assign s_q   = sqB_q;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mA_q  <= mC_q[i];
        cpA_q <= c_mul[59:30];
        spA_q <= s_mul[59:30];
        mB_q  <= mA_q;
        cpB_q <= cpA_q;
        spB_q <= spA_q;
        cqB_q <= c_rcp[61:32];
        sqB_q <= s_rcp[61:32];
        mC_q[i+1] <= mB_q;
        ct_q[i+1] <= rrv_pkg::OneQ30 - 31'(c_q);
        st_q[i+1] <= (i < 5) ? (rrv_pkg::OneQ30 - 31'(s_q)) : 31'(s_q);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vA_q      <= 1'b0;
        vB_q      <= 1'b0;
        vC_q[i+1] <= 1'b0;
      end else if (en) begin
        vA_q      <= vC_q[i];
        vB_q      <= vA_q;
        vC_q[i+1] <= vB_q;
      end
    end
  end

  // radius scaling
  logic        v_sc_q;
  logic [16:0] ms_q, mc_q;
  logic [1:0]  cor_sc_q, ix_sc_q;
  logic [30:0] s_sel, c_sel;
  logic [46:0] s_scl, c_scl;

  assign s_sel = mC_q[6].swap ? ct_q[6] : st_q[6];
  assign c_sel = mC_q[6].swap ? st_q[6] : ct_q[6];
  assign s_scl = 47'(geom_i.r) * 47'(s_sel) + 47'h2000_0000;
  assign c_scl = 47'(geom_i.r) * 47'(c_sel) + 47'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ms_q     <= s_scl[46:30];
      mc_q     <= c_scl[46:30];
      cor_sc_q <= mC_q[6].corner;
      ix_sc_q  <= mC_q[6].idx2;
    end
  end

  // placement
  logic [17:0] w18, h18, r18, wr, hr, ms18, mc18, vx, vy;
  assign w18  = {2'b00, geom_i.w};
  assign h18  = {2'b00, geom_i.h};
  assign r18  = {2'b00, geom_i.r};
  assign wr   = w18 - r18;
  assign hr   = h18 - r18;
  assign ms18 = {1'b0, ms_q};
  assign mc18 = {1'b0, mc_q};

  always_comb begin
    vx = '0;
    vy = '0;
    if (!geom_i.rounded) begin
      case (ix_sc_q)
        2'd0:    begin vx = '0;  vy = '0;  end
        2'd1:    begin vx = w18; vy = '0;  end
        2'd2:    begin vx = w18; vy = h18; end
        default: begin vx = '0;  vy = h18; end
      endcase
    end else begin
      case (cor_sc_q)
        2'd0:    begin vx = r18 - mc18; vy = r18 - ms18; end
        2'd1:    begin vx = wr + ms18;  vy = r18 - mc18; end
        2'd2:    begin vx = wr + mc18;  vy = hr + ms18;  end
        default: begin vx = r18 - ms18; vy = hr + mc18;  end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vertex_x_o <= vx;
      vertex_y_o <= vy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_rad_q     <= 1'b0;
      vC_q[0]     <= 1'b0;
      v_sc_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v_rad_q     <= pop_o;
      vC_q[0]     <= v_rad_q;
      v_sc_q      <= vC_q[6];
      out_valid_o <= v_sc_q;
    end
  end

  `RRV_ASSERT(a_hold_no_pop, (out_valid_o && out_stall_i) |-> !pop_o)
  `RRV_ASSERT(a_hold_valid, (out_valid_o && out_stall_i) |=> out_valid_o)

endmodule

`default_nettype wire

// ===== sv/rounded_rect_vertex_gen.sv =====
// Throughput: one vertex per cycle while the output is not stalled; set by
// the 10 + 17 stage index dividers and the 18 stage Horner sine/cosine
// pipeline, each taking one item a cycle.
// A 4-entry queue lets the front keep accepting while the output is stalled.
// Async active-low reset clears all valid flags, queue and config registers.
// ----------------------------------------------------------------------------
// rounded_rect_vertex_gen
// Rounded rectangle outline vertex generator, top level and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_rect_vertex_gen (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [9:0]  vertex_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [17:0]      vertex_x_o,
  output logic [17:0]      vertex_y_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] width_q, height_q, radius_q;
  logic [10:0] count_q;
  logic [10:0] pc;
  logic [8:0]  arc_len;
  logic [7:0]  arc_div;
  rrv_pkg::geom_t geom;

  logic           push, pop, full, empty;
  rrv_pkg::item_t push_data, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      radius_q <= '0;
      count_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rrv_pkg::RegWidth:  width_q  <= cfg_data_i;
        rrv_pkg::RegHeight: height_q <= cfg_data_i;
        rrv_pkg::RegRadius: radius_q <= cfg_data_i;
        rrv_pkg::RegCount:  count_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign pc      = (count_q > 11'(rrv_pkg::MaxPoints)) ? 11'(rrv_pkg::MaxPoints) : count_q;
  assign arc_len = pc[10:2];
  assign arc_div = 8'(arc_len - 9'd1);
  assign geom    = '{w: width_q, h: height_q, r: radius_q,
                     rounded: (radius_q != '0) && (pc >= 11'd8)};

  rrv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vertex_index_i (vertex_index_i),
    .arc_len_i      (arc_len),
    .arc_div_i      (arc_div),
    .full_i         (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  rrv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  rrv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vertex_x_o  (vertex_x_o),
    .vertex_y_o  (vertex_y_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/rounded_rect_vertex_gen_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_vertex_gen_tb
// Drives vertex indices through several outline shapes and compares each
// vertex against a fixed point outline model held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_rect_vertex_gen_tb;

  localparam longint unsigned OneQ = 64'd1 << 30;
  localparam longint unsigned HalfPi = 64'd1686629713;
  localparam longint unsigned MaxPc = 64'(rrv_pkg::MaxPoints);
  localparam int Latency = 50;
  localparam longint MaxCycles = 400000;

  typedef struct {
    logic [9:0]  index;
    logic        known;
    logic [17:0] x;
    logic [17:0] y;
  } stim_row_t;

  typedef struct {
    logic [17:0] x;
    logic [17:0] y;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [9:0]  vertex_index_i = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_stall_o, out_valid_o, cfg_ready_o;
  logic [17:0] vertex_x_o, vertex_y_o;

  rounded_rect_vertex_gen dut (.*);

  always #4 clk_i = ~clk_i;

  longint unsigned shape_w, shape_h, shape_r, shape_n;
  vertex_t pending_vertices[$];
  int  fail_count = 0;
  longint cycle_count = 0;
  bit  hold_req = 1'b0;
  bit  hold_off = 1'b0;
  bit  quiet_sink = 1'b0;

  function automatic longint unsigned sine_q(longint unsigned a);
    longint unsigned a2, t;
    longint unsigned dv[5] = '{110, 72, 42, 20, 6};
    a2 = (a * a) >> 30;
    t = OneQ;
    for (int i = 0; i < 5; i++) t = OneQ - ((a2 * t) >> 30) / dv[i];
    return (a * t) >> 30;
  endfunction

  function automatic longint unsigned cosine_q(longint unsigned a);
    longint unsigned a2, t;
    longint unsigned dv[6] = '{132, 90, 56, 30, 12, 2};
    a2 = (a * a) >> 30;
    t = OneQ;
    for (int i = 0; i < 6; i++) t = OneQ - ((a2 * t) >> 30) / dv[i];
    return t;
  endfunction

  function automatic longint arc_offset(longint unsigned trig, bit neg);
    longint m;
    m = longint'((shape_r * trig + (64'd1 << 29)) >> 30);
    return neg ? -m : m;
  endfunction

  function automatic vertex_t outline_vertex(logic [9:0] idx);
    longint unsigned pc, c, corner, k, f, a, rad, s, co;
    longint w, h, r, vx, vy;
    vertex_t v;
    w = longint'(shape_w);
    h = longint'(shape_h);
    r = longint'(shape_r);
    pc = shape_n > MaxPc ? MaxPc : shape_n;
    if (shape_r == 64'd0 || pc < 64'd8) begin
      case (idx[1:0])
        2'd0: begin vx = 0; vy = 0; end
        2'd1: begin vx = w; vy = 0; end
        2'd2: begin vx = w; vy = h; end
        default: begin vx = 0; vy = h; end
      endcase
    end else begin
      c = (pc - 64'd4) / 64'd4;
      corner = 64'(idx) / (c + 64'd1);
      k = 64'(idx) % (c + 64'd1);
      f = (k << 16) / c;
      if (f <= 64'd32768) begin
        rad = (f * HalfPi) >> 16;
        s = sine_q(rad);
        co = cosine_q(rad);
      end else begin
        a = 64'd65536 - f;
        rad = (a * HalfPi) >> 16;
        s = cosine_q(rad);
        co = sine_q(rad);
      end
      case (corner)
        64'd0: begin vx = r + arc_offset(co, 1); vy = r + arc_offset(s, 1); end
        64'd1: begin vx = w - r + arc_offset(s, 0); vy = r + arc_offset(co, 1); end
        64'd2: begin vx = w - r + arc_offset(co, 0); vy = h - r + arc_offset(s, 0); end
        default: begin vx = r + arc_offset(s, 1); vy = h - r + arc_offset(co, 0); end
      endcase
    end
    v.x = vx[17:0];
    v.y = vy[17:0];
    return v;
  endfunction

  task automatic write_reg(logic [1:0] which, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (which)
      rrv_pkg::RegWidth:  shape_w = 64'(data);
      rrv_pkg::RegHeight: shape_h = 64'(data);
      rrv_pkg::RegRadius: shape_r = 64'(data);
      default:            shape_n = 64'(data[10:0]);
    endcase
  endtask

  // point_count is 11 bits wide but the data bus is 16
  task automatic set_shape(logic [15:0] w, logic [15:0] h, logic [15:0] r,
                           logic [10:0] n);
    write_reg(rrv_pkg::RegWidth, w);
    write_reg(rrv_pkg::RegHeight, h);
    write_reg(rrv_pkg::RegRadius, r);
    write_reg(rrv_pkg::RegCount, {5'd0, n});
  endtask

  task automatic drain();
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic send_index(logic [9:0] idx, vertex_t v);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    pending_vertices.push_back(v);
  endtask

  task automatic random_run(int count);
    logic [9:0] idx;
    longint unsigned span;
    for (int i = 0; i < count; i++) begin
      span = (shape_n > MaxPc) ? MaxPc : shape_n;
      if ($urandom_range(0, 9) < 8 && span > 0)
        idx = 10'($urandom_range(0, 32'(span - 64'd1)));
      else idx = 10'($urandom);
      send_index(idx, outline_vertex(idx));
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sink: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d", vertex_x_o, vertex_y_o);
        fail_count++;
      end else begin
        want = pending_vertices.pop_front();
        if (vertex_x_o !== want.x) begin
          $error("vertex_x expected %0d actual %0d", want.x, vertex_x_o);
          fail_count++;
        end
        if (vertex_y_o !== want.y) begin
          $error("vertex_y expected %0d actual %0d", want.y, vertex_y_o);
          fail_count++;
        end
      end
    end
    if (hold_off) out_stall_i <= 1'b1;
    else if (quiet_sink) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_stall_i <= 1'b1;
    else if (out_stall_i && $urandom_range(0, 3) != 0) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 9) < 2);
  end

  initial begin
    wait (hold_req);
    repeat (20) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  stim_row_t directed[$];

  initial begin
    vertex_t v;
    shape_w = 0; shape_h = 0; shape_r = 0; shape_n = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset shape: all corners collapse to the origin
    directed.push_back('{10'd0, 1'b1, 18'd0, 18'd0});
    directed.push_back('{10'd1023, 1'b1, 18'd0, 18'd0});
    foreach (directed[i]) begin
      v = directed[i].known ? vertex_t'{directed[i].x, directed[i].y}
                            : outline_vertex(directed[i].index);
      send_index(directed[i].index, v);
    end
    in_valid_i <= 1'b0;
    drain();

    // square corners at max size, and a count too small to round
    set_shape(16'hFFFF, 16'hFFFF, 16'd0, 11'd64);
    directed = '{};
    directed.push_back('{10'd0, 1'b1, 18'd0, 18'd0});
    directed.push_back('{10'd1, 1'b1, 18'h0FFFF, 18'd0});
    directed.push_back('{10'd2, 1'b1, 18'h0FFFF, 18'h0FFFF});
    directed.push_back('{10'd1023, 1'b1, 18'd0, 18'h0FFFF});
    foreach (directed[i]) send_index(directed[i].index,
      vertex_t'{directed[i].x, directed[i].y});
    in_valid_i <= 1'b0;
    drain();
    set_shape(16'd1000, 16'd500, 16'd50, 11'd7);
    for (int i = 0; i < 4; i++) send_index(10'(i), outline_vertex(10'(i)));
    in_valid_i <= 1'b0;
    drain();

    // smallest rounded count, index past outline, radius that crosses over
    set_shape(16'd1600, 16'd800, 16'd100, 11'd8);
    for (int i = 0; i < 10; i++) send_index(10'(i), outline_vertex(10'(i)));
    send_index(10'd1023, outline_vertex(10'd1023));
    in_valid_i <= 1'b0;
    drain();
    set_shape(16'd100, 16'd0, 16'hFFFF, 11'd2047);
    for (int i = 0; i < 5; i++) send_index(10'(i * 255), outline_vertex(10'(i * 255)));
    in_valid_i <= 1'b0;
    drain();

    // random shapes: first block overlaps the sink hold-off
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0)
        set_shape(16'($urandom), 16'($urandom),
                  (ph == 3) ? 16'hFFFF : ($urandom_range(0, 3) == 0)
                  ? 16'($urandom) : 16'($urandom_range(1, 2000)),
                  11'($urandom_range(0, 2047)));
      else begin
        set_shape(16'd20000, 16'd12000, 16'd3000, 11'd1024);
        hold_req = 1'b1;
      end
      random_run(100);
      drain();
    end
    quiet_sink = 1'b1;
    set_shape(16'd4000, 16'd3000, 16'd400, 11'd40);
    random_run(50);
    drain();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/rrv_pkg.sv
sv/rrv_fifo.sv
sv/rrv_front.sv
sv/rrv_back.sv
sv/rounded_rect_vertex_gen.sv
tb/sv/rounded_rect_vertex_gen_tb.sv
